// ===== hdl/rri_pkg.sv =====
// ---------------------------------------------------------------------------
// rri_pkg - shared types and constants for the ray/rectangle test
// Register indexes, field widths and the divider geometry.
// ---------------------------------------------------------------------------
package rri_pkg;

   localparam int COORD_W = 20;            // signed Q7.12 coordinate
   localparam int VEC_W   = 3 * COORD_W;   // packed x,y,z
   localparam int LEN_W   = 28;            // squared edge length, Q.12
   localparam int EPS_W   = 12;            // min distance, Q.12
   localparam int DIST_W  = 32;            // hit distance, Q20.12
   localparam int CSR_IDX_W = 3;

   // divider geometry: magnitude widths and quotient bits
   localparam int DIV_NW  = 62;
   localparam int DIV_DW  = 40;
   localparam int DIV_QW  = 32;
   localparam int DIV_LAT = DIV_QW + 1;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type REG_CORNER   = 3'd0;
   localparam csr_idx_type REG_EDGE_A   = 3'd1;
   localparam csr_idx_type REG_EDGE_B   = 3'd2;
   localparam csr_idx_type REG_NORMAL   = 3'd3;
   localparam csr_idx_type REG_A_LEN_SQ = 3'd4;
   localparam csr_idx_type REG_B_LEN_SQ = 3'd5;
   localparam csr_idx_type REG_MIN_DIST = 3'd6;

   typedef logic signed [COORD_W-1:0] coord_type;

   // sideband that travels next to the divider
   typedef struct packed {
      coord_type       org_x;
      coord_type       org_y;
      coord_type       org_z;
      logic [3:0]      neg;       // quotient sign: t, x, y, z
      logic            den_zero;
   } side_type;

endpackage

// ===== hdl/ray_rectangle_intersect.sv =====
// ---------------------------------------------------------------------------
// ray_rectangle_intersect - ray against configured rectangle, pipelined
// Plane distance by exact fixed-point division, hit point, edge tests.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | origin xyz, direction xyz
//   rsp     | out       | rsp_valid/stall    | is_hit, hit_distance, hit xyz
//   csr     | in        | csr_valid/ready    | csr_index, csr_data
//
// One ray enters per cycle; t and the hit point come from the 32-stage
// bit-serial divider pipeline between stage 4 and stage 6.
// Reset (synchronous) clears all valid bits and loads the register defaults.
// A stalled result freezes the whole pipeline; input is stalled then.
// ---------------------------------------------------------------------------
module ray_rectangle_intersect (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  rri_pkg::coord_type       req_origin_x,
   input  rri_pkg::coord_type       req_origin_y,
   input  rri_pkg::coord_type       req_origin_z,
   input  rri_pkg::coord_type       req_direction_x,
   input  rri_pkg::coord_type       req_direction_y,
   input  rri_pkg::coord_type       req_direction_z,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_is_hit,
   output logic [31:0]              rsp_hit_distance,
   output rri_pkg::coord_type       rsp_hit_x,
   output rri_pkg::coord_type       rsp_hit_y,
   output rri_pkg::coord_type       rsp_hit_z,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  rri_pkg::csr_idx_type     csr_index,
   input  logic [59:0]              csr_data
);
   import rri_pkg::*;

   function automatic coord_type elem(input logic [VEC_W-1:0] v, input int i);
      return v[i*COORD_W +: COORD_W];
   endfunction

   function automatic coord_type sat20(input logic signed [21:0] v);
      if (v > 22'sd524287)       return 20'sd524287;
      else if (v < -22'sd524288) return -20'sd524288;
      else                       return COORD_W'(v);
   endfunction

   // configuration registers
   logic [VEC_W-1:0] corner_ff, edge_a_ff, edge_b_ff, normal_ff;
   logic [LEN_W-1:0] a_len_ff, b_len_ff;
   logic [EPS_W-1:0] min_dist_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff   <= 60'd1148417904980520960;
         edge_a_ff   <= 60'd9007199254740992;
         edge_b_ff   <= 60'd8192;
         normal_ff   <= 60'd4294967296;
         a_len_ff    <= 28'd16384;
         b_len_ff    <= 28'd16384;
         min_dist_ff <= 12'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_CORNER:   corner_ff   <= csr_data;
            REG_EDGE_A:   edge_a_ff   <= csr_data;
            REG_EDGE_B:   edge_b_ff   <= csr_data;
            REG_NORMAL:   normal_ff   <= csr_data;
            REG_A_LEN_SQ: a_len_ff    <= csr_data[LEN_W-1:0];
            REG_B_LEN_SQ: b_len_ff    <= csr_data[LEN_W-1:0];
            REG_MIN_DIST: min_dist_ff <= csr_data[EPS_W-1:0];
            default: ;
         endcase
      end
   end

   // global advance: move when the output register is free or drains
   logic en;
   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   coord_type org_in [3];
   coord_type dir_in [3];
   assign org_in[0] = req_origin_x;
   assign org_in[1] = req_origin_y;
   assign org_in[2] = req_origin_z;
   assign dir_in[0] = req_direction_x;
   assign dir_in[1] = req_direction_y;
   assign dir_in[2] = req_direction_z;

   // valid bits
   logic v1_ff, v2_ff, v3_ff, v4_ff, v6_ff, v7_ff;
   logic [DIV_LAT-1:0] vd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
         vd_ff <= '0;   v6_ff <= 1'b0; v7_ff <= 1'b0; rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         vd_ff <= {vd_ff[DIV_LAT-2:0], v4_ff};
         v6_ff <= vd_ff[DIV_LAT-1];
         v7_ff <= v6_ff;
         rsp_valid_ff <= v7_ff;
      end
   end

   // stage 1: corner minus origin
   logic signed [20:0] s1_diff_ff [3];
   coord_type          s1_org_ff [3];
   coord_type          s1_dir_ff [3];
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s1_diff_ff[i] <= 21'(elem(corner_ff, i)) - 21'(org_in[i]);
            s1_org_ff[i]  <= org_in[i];
            s1_dir_ff[i]  <= dir_in[i];
         end
      end
   end

   // stage 2: per-axis products with the normal
   logic signed [40:0] s2_pn_ff [3];
   logic signed [39:0] s2_dn_ff [3];
   coord_type          s2_org_ff [3];
   coord_type          s2_dir_ff [3];
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s2_pn_ff[i]  <= 41'(s1_diff_ff[i]) * 41'(elem(normal_ff, i));
            s2_dn_ff[i]  <= 40'(s1_dir_ff[i]) * 40'(elem(normal_ff, i));
            s2_org_ff[i] <= s1_org_ff[i];
            s2_dir_ff[i] <= s1_dir_ff[i];
         end
      end
   end

   // stage 3: dot products
   logic signed [41:0] s3_num_ff;
   logic signed [40:0] s3_den_ff;
   coord_type          s3_org_ff [3];
   coord_type          s3_dir_ff [3];
   always_ff @(posedge clock) begin
      if (en) begin
         s3_num_ff <= 42'(s2_pn_ff[0]) + 42'(s2_pn_ff[1]) + 42'(s2_pn_ff[2]);
         s3_den_ff <= 41'(s2_dn_ff[0]) + 41'(s2_dn_ff[1]) + 41'(s2_dn_ff[2]);
         for (int i = 0; i < 3; i++) begin
            s3_org_ff[i] <= s2_org_ff[i];
            s3_dir_ff[i] <= s2_dir_ff[i];
         end
      end
   end

   // stage 4: dividends for t and the three hit offsets
   logic signed [61:0] s4_nd_ff [3];
   logic signed [61:0] s4_nt_ff;
   logic signed [40:0] s4_den_ff;
   coord_type          s4_org_ff [3];
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s4_nd_ff[i]  <= 62'(s3_num_ff) * 62'(s3_dir_ff[i]);
            s4_org_ff[i] <= s3_org_ff[i];
         end
         s4_nt_ff  <= 62'(s3_num_ff) <<< 12;
         s4_den_ff <= s3_den_ff;
      end
   end

   // magnitudes and quotient signs into the dividers
   logic [DIV_NW-1:0] num_mag [4];
   logic [DIV_DW-1:0] den_mag;
   logic              den_neg;
   logic signed [61:0] dividend [4];
   side_type          side_in;

   assign dividend[0] = s4_nt_ff;
   assign dividend[1] = s4_nd_ff[0];
   assign dividend[2] = s4_nd_ff[1];
   assign dividend[3] = s4_nd_ff[2];
   assign den_neg = s4_den_ff[40];
   assign den_mag = DIV_DW'(den_neg ? -s4_den_ff : s4_den_ff);

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         num_mag[k]     = DIV_NW'(dividend[k][61] ? -dividend[k] : dividend[k]);
         side_in.neg[k] = dividend[k][61] ^ den_neg;
      end
      side_in.org_x    = s4_org_ff[0];
      side_in.org_y    = s4_org_ff[1];
      side_in.org_z    = s4_org_ff[2];
      side_in.den_zero = (s4_den_ff == '0);
   end

   logic [DIV_QW-1:0] quot [4];
   logic              ovf  [4];

   for (genvar k = 0; k < 4; k++) begin : g_div
      rri_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div (
         .clock   (clock),
         .en      (en),
         .num_mag (num_mag[k]),
         .den_mag (den_mag),
         .quot    (quot[k]),
         .ovf     (ovf[k])
      );
   end

   // sideband delay matched to the divider
   side_type side_ff [DIV_LAT];
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int j = 1; j < DIV_LAT; j++) side_ff[j] <= side_ff[j-1];
      end
   end

   side_type  side_out;
   coord_type org_out [3];
   assign side_out   = side_ff[DIV_LAT-1];
   assign org_out[0] = side_out.org_x;
   assign org_out[1] = side_out.org_y;
   assign org_out[2] = side_out.org_z;

   // stage 6: distance test and saturated hit point
   coord_type   s6_p_ff [3];
   logic [31:0] s6_t_ff;
   logic        s6_miss_ff;
   coord_type   p_in [3];
   logic        miss_in;

   always_comb begin
      logic               big;
      logic signed [21:0] off;
      logic               t_neg;
      for (int i = 0; i < 3; i++) begin
         big = ovf[i+1] || (quot[i+1][31:20] != '0);
         off = 22'($signed({2'b00, quot[i+1][19:0]}));
         if (big)
            p_in[i] = side_out.neg[i+1] ? -20'sd524288 : 20'sd524287;
         else
            p_in[i] = sat20(22'(org_out[i]) + (side_out.neg[i+1] ? -off : off));
      end
      t_neg   = side_out.neg[0] && (ovf[0] || quot[0] != '0);
      miss_in = side_out.den_zero || t_neg ||
                (!ovf[0] && quot[0] <= 32'(min_dist_ff));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) s6_p_ff[i] <= p_in[i];
         s6_t_ff    <= ovf[0] ? '1 : quot[0];
         s6_miss_ff <= miss_in;
      end
   end

   // stage 7: edge projection products
   logic signed [40:0] s7_pa_ff [3];
   logic signed [40:0] s7_pb_ff [3];
   coord_type          s7_p_ff [3];
   logic [31:0]        s7_t_ff;
   logic               s7_miss_ff;
   logic signed [20:0] rel [3];

   always_comb begin
      for (int i = 0; i < 3; i++) rel[i] = 21'(s6_p_ff[i]) - 21'(elem(corner_ff, i));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s7_pa_ff[i] <= 41'(rel[i]) * 41'(elem(edge_a_ff, i));
            s7_pb_ff[i] <= 41'(rel[i]) * 41'(elem(edge_b_ff, i));
            s7_p_ff[i]  <= s6_p_ff[i];
         end
         s7_t_ff    <= s6_t_ff;
         s7_miss_ff <= s6_miss_ff;
      end
   end

   // stage 8: projection bounds, result register
   logic signed [42:0] proj_a, proj_b, lim_a, lim_b;
   logic               hit;
   assign proj_a = 43'(s7_pa_ff[0]) + 43'(s7_pa_ff[1]) + 43'(s7_pa_ff[2]);
   assign proj_b = 43'(s7_pb_ff[0]) + 43'(s7_pb_ff[1]) + 43'(s7_pb_ff[2]);
   assign lim_a  = $signed({3'b000, a_len_ff, 12'h000});
   assign lim_b  = $signed({3'b000, b_len_ff, 12'h000});
   assign hit    = !s7_miss_ff && !proj_a[42] && (proj_a <= lim_a) &&
                   !proj_b[42] && (proj_b <= lim_b);

   logic        is_hit_ff;
   logic [31:0] dist_ff;
   coord_type   hx_ff, hy_ff, hz_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         is_hit_ff <= hit;
         dist_ff   <= hit ? s7_t_ff : '0;
         hx_ff     <= hit ? s7_p_ff[0] : '0;
         hy_ff     <= hit ? s7_p_ff[1] : '0;
         hz_ff     <= hit ? s7_p_ff[2] : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_hit       = is_hit_ff;
   assign rsp_hit_distance = dist_ff;
   assign rsp_hit_x        = hx_ff;
   assign rsp_hit_y        = hy_ff;
   assign rsp_hit_z        = hz_ff;

   // checks
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_hit |-> rsp_hit_distance == '0 && rsp_hit_x == '0 &&
      rsp_hit_y == '0 && rsp_hit_z == '0)
      else $error("miss result carries nonzero payload");

   a_hit_far: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_hit |-> rsp_hit_distance > 32'(min_dist_ff))
      else $error("hit at or below min distance");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while output free");

endmodule

// ===== hdl/rri_div.sv =====
// ---------------------------------------------------------------------------
// rri_div - pipelined restoring divider, one quotient bit per stage
// Divides unsigned magnitudes; flags quotients that do not fit in QW bits.
// ---------------------------------------------------------------------------
module rri_div #(
   parameter int NW = 62,
   parameter int DW = 40,
   parameter int QW = 32
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num_mag,
   input  logic [DW-1:0] den_mag,
   output logic [QW-1:0] quot,
   output logic          ovf
);
   localparam int CW = DW + QW;

   logic [NW-1:0] rem_ff [QW+1];
   logic [DW-1:0] den_ff [QW+1];
   logic [QW-1:0] quo_ff [QW+1];
   logic          ovf_ff [QW+1];

   // load stage: detect a quotient of more than QW bits
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num_mag;
         den_ff[0] <= den_mag;
         quo_ff[0] <= '0;
         ovf_ff[0] <= CW'(num_mag) >= (CW'(den_mag) << QW);
      end
   end

   // one trial subtract per stage, most significant bit first
   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic [CW-1:0] shifted;
      logic [CW-1:0] rem_ext;
      logic          ge;
      assign shifted = CW'(den_ff[s]) << (QW - 1 - s);
      assign rem_ext = CW'(rem_ff[s]);
      assign ge      = rem_ext >= shifted;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s+1] <= ge ? NW'(rem_ext - shifted) : rem_ff[s];
            den_ff[s+1] <= den_ff[s];
            quo_ff[s+1] <= quo_ff[s] | (ge ? (QW'(1) << (QW - 1 - s)) : '0);
            ovf_ff[s+1] <= ovf_ff[s];
         end
      end
   end

   assign quot = quo_ff[QW];
   assign ovf  = ovf_ff[QW];

endmodule

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top - self-checking bench for ray_rectangle_intersect
// Streams rays against a series of rectangle setups and compares every
// result with a fixed-point intersection predictor, in transfer order.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rri_pkg::*;

   typedef struct {
      coord_type ox, oy, oz, dx, dy, dz;
   } ray_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] distance;
      coord_type   x, y, z;
   } hit_type;

   logic              clock, reset;
   logic              req_valid, req_stall;
   coord_type         req_origin_x, req_origin_y, req_origin_z;
   coord_type         req_direction_x, req_direction_y, req_direction_z;
   logic              rsp_valid, rsp_stall, rsp_is_hit;
   logic [31:0]       rsp_hit_distance;
   coord_type         rsp_hit_x, rsp_hit_y, rsp_hit_z;
   logic              csr_valid, csr_ready;
   csr_idx_type       csr_index;
   logic [59:0]       csr_data;

   // shadow copy of the rectangle setup
   logic [59:0]       rect_corner, rect_a, rect_b, rect_n;
   logic [27:0]       rect_a_len, rect_b_len;
   logic [11:0]       rect_eps;

   ray_type           pending_rays[$];
   hit_type           expected_hits[$];
   int                req_gap, stall_left, mismatches;
   bit                req_taken, quiet;

   ray_rectangle_intersect DUT (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end

   function automatic longint coord_of(logic [59:0] v, int i);
      return longint'($signed(v[i*20 +: 20]));
   endfunction

   function automatic logic [59:0] pack3(longint x, longint y, longint z);
      logic [19:0] px, py, pz;
      px = x[19:0];
      py = y[19:0];
      pz = z[19:0];
      return {pz, py, px};
   endfunction

   // plane distance, hit point and edge containment for one ray
   function automatic hit_type predict_hit(ray_type r);
      longint o[3], d[3], c[3], ea[3], eb[3], nv[3], p[3];
      longint num, den, t, pa, pb;
      hit_type res;
      res = '{hit: 0, distance: 0, x: 0, y: 0, z: 0};
      o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
      d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
      num = 0; den = 0; pa = 0; pb = 0;
      for (int i = 0; i < 3; i++) begin
         c[i]  = coord_of(rect_corner, i);
         ea[i] = coord_of(rect_a, i);
         eb[i] = coord_of(rect_b, i);
         nv[i] = coord_of(rect_n, i);
         num += (c[i] - o[i]) * nv[i];
         den += d[i] * nv[i];
      end
      if (den == 0) return res;
      t = (num * 4096) / den;
      if (t <= longint'(rect_eps)) return res;
      for (int i = 0; i < 3; i++) begin
         p[i] = o[i] + (num * d[i]) / den;
         if (p[i] > 524287) p[i] = 524287;
         if (p[i] < -524288) p[i] = -524288;
         pa += (p[i] - c[i]) * ea[i];
         pb += (p[i] - c[i]) * eb[i];
      end
      if (pa < 0 || pa > longint'(rect_a_len) * 4096) return res;
      if (pb < 0 || pb > longint'(rect_b_len) * 4096) return res;
      res.hit      = 1;
      res.distance = (t > 64'hFFFFFFFF) ? 32'hFFFFFFFF : t[31:0];
      res.x        = p[0][19:0];
      res.y        = p[1][19:0];
      res.z        = p[2][19:0];
      return res;
   endfunction

   // accept rays, check results
   always @(posedge clock) begin
      hit_type got, want;
      ray_type r;
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) begin
         r = '{req_origin_x, req_origin_y, req_origin_z,
               req_direction_x, req_direction_y, req_direction_z};
         expected_hits.push_back(predict_hit(r));
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_is_hit, rsp_hit_distance, rsp_hit_x, rsp_hit_y, rsp_hit_z};
         if (expected_hits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
         end else begin
            want = expected_hits.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp hit=%0d t=%h p=(%0d,%0d,%0d) got hit=%0d t=%h p=(%0d,%0d,%0d)",
                           want.hit, want.distance, want.x, want.y, want.z,
                           got.hit, got.distance, got.x, got.y, got.z);
            end
         end
      end
   end

   // drive rays with random gaps
   always @(negedge clock) begin
      ray_type r;
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 0;
         end else if (pending_rays.size() > 0) begin
            r = pending_rays.pop_front();
            req_origin_x <= r.ox; req_origin_y <= r.oy; req_origin_z <= r.oz;
            req_direction_x <= r.dx; req_direction_y <= r.dy; req_direction_z <= r.dz;
            req_valid <= 1;
            if (!quiet && $urandom_range(0, 5) == 0) req_gap = $urandom_range(1, 4);
         end else begin
            req_valid <= 0;
         end
      end
   end

   // stall results in random bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   task automatic write_reg(csr_idx_type idx, logic [59:0] val);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_CORNER:   rect_corner = val;
         REG_EDGE_A:   rect_a      = val;
         REG_EDGE_B:   rect_b      = val;
         REG_NORMAL:   rect_n      = val;
         REG_A_LEN_SQ: rect_a_len  = val[27:0];
         REG_B_LEN_SQ: rect_b_len  = val[27:0];
         REG_MIN_DIST: rect_eps    = val[11:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // hold until every ray has gone through and the pipeline is empty
   task automatic drain();
      while (pending_rays.size() > 0 || req_valid || expected_hits.size() > 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic add_ray(longint ox, oy, oz, dx, dy, dz);
      pending_rays.push_back('{ox[19:0], oy[19:0], oz[19:0],
                               dx[19:0], dy[19:0], dz[19:0]});
   endtask

   function automatic longint rnd(longint lo, longint hi);
      return lo + longint'($urandom_range(0, hi - lo));
   endfunction

   initial begin
      longint ax, bx, nx, la, lb, c[3], va[3], vb[3], nv[3], o[3], tg[3];
      longint fa, fb;
      reset = 1; csr_valid = 0; csr_index = '0; csr_data = '0;
      req_valid = 0; rsp_stall = 0; req_gap = 0; stall_left = 0;
      req_origin_x = '0; req_origin_y = '0; req_origin_z = '0;
      req_direction_x = '0; req_direction_y = '0; req_direction_z = '0;
      mismatches = 0; quiet = 0;
      rect_corner = 60'd1148417904980520960; rect_a = 60'd9007199254740992;
      rect_b = 60'd8192; rect_n = 60'd4294967296;
      rect_a_len = 28'd16384; rect_b_len = 28'd16384; rect_eps = 12'd1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed rays against the default square in the y = 0 plane
      add_ray(0, 4096, 0, 0, -4096, 0);               // center hit
      add_ray(0, 4096, 0, 4096, 0, 0);                // parallel, zero denominator
      add_ray(0, 4096, 0, 0, 4096, 0);                // behind origin
      add_ray(0, 1, 0, 0, -4096, 0);                  // t at epsilon
      add_ray(0, 2, 0, 0, -4096, 0);                  // t just above epsilon
      add_ray(4096, 4096, 4096, 0, -4096, 0);         // far corner on the edge
      add_ray(-4096, 4096, -4096, 0, -4096, 0);       // near corner
      add_ray(4097, 4096, 0, 0, -4096, 0);            // just outside edge
      add_ray(0, 524287, 0, 0, -1, 0);                // huge t, distance still in range
      add_ray(524287, 524287, 524287, 524287, 524287, 524287);
      add_ray(-524288, -524288, -524288, -524288, -524288, -524288);
      add_ray(-524288, 524287, 0, 524287, -524288, 0); // extreme origin and direction, still a hit
      add_ray(0, -4096, 0, 0, 4096, 0);               // from below
      add_ray(2048, 8192, -2048, 1024, -4096, 512);
      drain();
      write_reg(csr_idx_type'(7), '1);                // unused index, ignored
      add_ray(0, 4096, 0, 0, -4096, 0);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         quiet = (ph == 7);
         if (ph == 3) begin
            // all-ones setup: every register at its top value
            write_reg(REG_CORNER, '1); write_reg(REG_EDGE_A, '1);
            write_reg(REG_EDGE_B, '1); write_reg(REG_NORMAL, '1);
            write_reg(REG_A_LEN_SQ, 60'hFFFFFFF); write_reg(REG_B_LEN_SQ, 60'hFFFFFFF);
            write_reg(REG_MIN_DIST, 60'hFFF);
         end else if (ph == 5) begin
            write_reg(REG_NORMAL, '0); write_reg(REG_MIN_DIST, '0);
            write_reg(REG_A_LEN_SQ, '0); write_reg(REG_B_LEN_SQ, '0);
         end else begin
            // axis-aligned rectangle with a unit normal along the third axis
            ax = $urandom_range(0, 2);
            bx = (ax + 1 + $urandom_range(0, 1)) % 3;
            nx = 3 - ax - bx;
            la = rnd(256, 65536); lb = rnd(256, 65536);
            for (int i = 0; i < 3; i++) begin
               c[i] = rnd(-8 * 4096, 8 * 4096);
               va[i] = 0; vb[i] = 0; nv[i] = 0;
            end
            va[ax] = $urandom_range(0, 1) ? la : -la;
            vb[bx] = $urandom_range(0, 1) ? lb : -lb;
            nv[nx] = $urandom_range(0, 1) ? 4096 : -4096;
            write_reg(REG_CORNER, pack3(c[0], c[1], c[2]));
            write_reg(REG_EDGE_A, pack3(va[0], va[1], va[2]));
            write_reg(REG_EDGE_B, pack3(vb[0], vb[1], vb[2]));
            write_reg(REG_NORMAL, pack3(nv[0], nv[1], nv[2]));
            write_reg(REG_A_LEN_SQ, 60'((la * la) / 4096));
            write_reg(REG_B_LEN_SQ, 60'((lb * lb) / 4096));
            case (ph % 3)
               0: write_reg(REG_MIN_DIST, '0);
               1: write_reg(REG_MIN_DIST, 60'd4095);
               default: write_reg(REG_MIN_DIST, 60'($urandom_range(0, 4095)));
            endcase
         end
         for (int k = 0; k < 200; k++) begin
            if (ph == 3 || ph == 5 || $urandom_range(0, 4) == 0) begin
               add_ray(rnd(-524288, 524287), rnd(-524288, 524287), rnd(-524288, 524287),
                       rnd(-524288, 524287), rnd(-524288, 524287), rnd(-524288, 524287));
            end else begin
               // aim at a point near the rectangle
               fa = rnd(-200, 1200); fb = rnd(-200, 1200);
               for (int i = 0; i < 3; i++) begin
                  tg[i] = c[i] + (va[i] * fa) / 1000 + (vb[i] * fb) / 1000;
                  o[i]  = rnd(-16 * 4096, 16 * 4096);
               end
               if ($urandom_range(0, 3) == 0) begin
                  add_ray(o[0], o[1], o[2], (tg[0] - o[0]) / 8, (tg[1] - o[1]) / 8,
                          (tg[2] - o[2]) / 8);
               end else begin
                  add_ray(o[0], o[1], o[2], tg[0] - o[0], tg[1] - o[1], tg[2] - o[2]);
               end
            end
         end
         drain();
      end

      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
